// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the matrix multiply block.
// No dependencies; define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle check failed");
// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ----- hdl/mmcz_pkg.sv -----
// Shared types, constants and helper functions of the matrix multiply block.
// No dependencies; the RTL files and the testbench refer to it by scoped names.
package mmcz_pkg;

    // Sizes.
    localparam int MAX_DIM    = 8;
    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int DEPTH      = MAX_DIM * MAX_DIM;
    localparam int DIM_W      = 4;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = 7;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int RND_W      = PROD_W - FRAC_W;
    localparam int ACC_W      = RND_W + IDX_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int ROUND_HALF = 1 << (FRAC_W - 1);

    // Command codes.
    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALAR = 3'd5;

    // Input request.
    typedef struct packed {
        logic [1:0]               command;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    // Result request.
    typedef struct packed {
        logic [IDX_W-1:0]         out_row;
        logic [IDX_W-1:0]         out_col;
        logic signed [DATA_W-1:0] out_value;
        logic                     last;
        logic [CNT_W-1:0]         zero_count;
        logic [CNT_W-1:0]         nonzero_count;
        logic                     size_error;
    } t_out_item;

    // Control tag that travels with each multiply-accumulate step.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_k;
        logic             last_elem;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

    // Finished element from the accumulator.
    typedef struct packed {
        logic                    valid;
        logic                    last_elem;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [ACC_W-1:0] acc;
    } t_mac_res;

    // A dimension of zero counts as one, anything above the maximum as the maximum.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (d > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = d;
        end
        return r;
    endfunction

    // Highest index in use for a dimension register.
    function automatic logic [IDX_W-1:0] last_idx(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] c;
        c = clamp_dim(d) - DIM_W'(1);
        return c[IDX_W-1:0];
    endfunction

    // Saturate the accumulator to a signed 32-bit value.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if ((&v[ACC_W-1:DATA_W-1]) || !(|v[ACC_W-1:DATA_W-1])) begin
            r = v[DATA_W-1:0];
        end else if (v[ACC_W-1]) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ----- hdl/mmcz_store.sv -----
// Element storage for matrices A and B, one write and one registered read each.
// Depends on mmcz_pkg for sizes.
module mmcz_store (
    input  logic                              i_clk,
    input  logic                              i_wr_a,
    input  logic                              i_wr_b,
    input  logic [mmcz_pkg::ADDR_W-1:0]       i_wr_addr,
    input  logic signed [mmcz_pkg::DATA_W-1:0] i_wr_data,
    input  logic                              i_rd_en,
    input  logic [mmcz_pkg::ADDR_W-1:0]       i_rd_addr_a,
    input  logic [mmcz_pkg::ADDR_W-1:0]       i_rd_addr_b,
    output logic signed [mmcz_pkg::DATA_W-1:0] o_rd_a,
    output logic signed [mmcz_pkg::DATA_W-1:0] o_rd_b
);

    logic signed [mmcz_pkg::DATA_W-1:0] r_mem_a [mmcz_pkg::DEPTH];
    logic signed [mmcz_pkg::DATA_W-1:0] r_mem_b [mmcz_pkg::DEPTH];
    logic signed [mmcz_pkg::DATA_W-1:0] r_rd_a;
    logic signed [mmcz_pkg::DATA_W-1:0] r_rd_b;

    // Matrix A: write on load, read while the pipeline advances.
    always_ff @(posedge i_clk) begin
        if (i_wr_a) begin
            r_mem_a[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem_a[i_rd_addr_a];
        end
    end

    // Matrix B: same organization.
    always_ff @(posedge i_clk) begin
        if (i_wr_b) begin
            r_mem_b[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_b <= r_mem_b[i_rd_addr_b];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

// ----- hdl/mmcz_mac.sv -----
// Shared multiply-accumulate unit: registered 32x32 product, then rounding
// to Q16.16 and a wide accumulate. Depends on mmcz_pkg.
module mmcz_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  mmcz_pkg::t_tag                     i_tag,
    input  logic signed [mmcz_pkg::DATA_W-1:0] i_a,
    input  logic signed [mmcz_pkg::DATA_W-1:0] i_b,
    output mmcz_pkg::t_mac_res                 o_res
);

    logic signed [mmcz_pkg::PROD_W-1:0] prod;
    logic signed [mmcz_pkg::PROD_W-1:0] r_prod;
    mmcz_pkg::t_tag                     r_ptag;
    logic signed [mmcz_pkg::PROD_W-1:0] prod_rnd;
    logic signed [mmcz_pkg::RND_W-1:0]  rnd;
    logic signed [mmcz_pkg::ACC_W-1:0]  rnd_ext;
    logic signed [mmcz_pkg::ACC_W-1:0]  acc_base;
    logic signed [mmcz_pkg::ACC_W-1:0]  r_acc;
    mmcz_pkg::t_tag                     r_atag;

    // Full-precision product of two Q16.16 operands.
    assign prod = mmcz_pkg::PROD_W'(i_a) * mmcz_pkg::PROD_W'(i_b);

    // Round half up: add one half LSB, then drop the fraction bits (floor).
    assign prod_rnd = r_prod + mmcz_pkg::PROD_W'(mmcz_pkg::ROUND_HALF);
    assign rnd      = prod_rnd[mmcz_pkg::PROD_W-1:mmcz_pkg::FRAC_W];
    assign rnd_ext  = {{(mmcz_pkg::ACC_W-mmcz_pkg::RND_W){rnd[mmcz_pkg::RND_W-1]}}, rnd};
    assign acc_base = r_ptag.first ? '0 : r_acc;

    // Product stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptag <= '0;
        end else if (i_en) begin
            r_ptag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_tag.valid) begin
            r_prod <= prod;
        end
    end

    // Accumulate stage; the first step of an element restarts the sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atag <= '0;
        end else if (i_en) begin
            r_atag <= r_ptag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && r_ptag.valid) begin
            r_acc <= acc_base + rnd_ext;
        end
    end

    // An element is complete when its final step has been accumulated.
    assign o_res.valid     = r_atag.valid && r_atag.last_k;
    assign o_res.last_elem = r_atag.last_elem;
    assign o_res.row       = r_atag.row;
    assign o_res.col       = r_atag.col;
    assign o_res.acc       = r_acc;

endmodule

// ----- hdl/matrix_multiply_count_zeros.sv -----
// Matrix multiplier with zero census: top level, sequencer and result register.
// Loads are written to storage as they are accepted. A compute issues one
// multiply-accumulate per cycle through the shared unit while the output is not
// stalled. A size error sends the sequencer to its error state, from which the
// error result goes to the result register. Reset clears control state and
// configuration registers; matrix storage is not cleared. Uses mmcz_pkg.
`include "assert_macros.svh"

module matrix_multiply_count_zeros (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  mmcz_pkg::t_in_item                    i_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output mmcz_pkg::t_out_item                   o_out,
    input  logic                                  i_cfg_we,
    input  logic [mmcz_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mmcz_pkg::DATA_W-1:0]           i_cfg_wdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_ERR  = 2'd3;

    // Configuration registers.
    logic                               r_mode;
    logic [mmcz_pkg::DIM_W-1:0]         r_a_rows;
    logic [mmcz_pkg::DIM_W-1:0]         r_a_cols;
    logic [mmcz_pkg::DIM_W-1:0]         r_b_rows;
    logic [mmcz_pkg::DIM_W-1:0]         r_b_cols;
    logic signed [mmcz_pkg::DATA_W-1:0] r_scalar;

    // Sequencer.
    logic [1:0]                 r_state;
    logic [1:0]                 n_state;
    logic [mmcz_pkg::IDX_W-1:0] r_i;
    logic [mmcz_pkg::IDX_W-1:0] r_j;
    logic [mmcz_pkg::IDX_W-1:0] r_k;
    logic [mmcz_pkg::IDX_W-1:0] n_i;
    logic [mmcz_pkg::IDX_W-1:0] n_j;
    logic [mmcz_pkg::IDX_W-1:0] n_k;
    logic [mmcz_pkg::IDX_W-1:0] r_last_i;
    logic [mmcz_pkg::IDX_W-1:0] r_last_j;
    logic [mmcz_pkg::IDX_W-1:0] r_last_k;

    logic in_acc;
    logic compute_req;
    logic size_err;
    logic start_ok;
    logic en;
    logic load_res;
    logic load_err;

    mmcz_pkg::t_tag     issue_tag;
    mmcz_pkg::t_tag     r_s1_tag;
    mmcz_pkg::t_mac_res mac_res;

    logic signed [mmcz_pkg::DATA_W-1:0] rd_a;
    logic signed [mmcz_pkg::DATA_W-1:0] rd_b;
    logic signed [mmcz_pkg::DATA_W-1:0] op_b;
    logic signed [mmcz_pkg::DATA_W-1:0] sat_val;

    logic [mmcz_pkg::CNT_W-1:0] r_zero_tally;
    logic [mmcz_pkg::CNT_W-1:0] r_nonzero_tally;
    logic [mmcz_pkg::CNT_W-1:0] n_zero_tally;
    logic [mmcz_pkg::CNT_W-1:0] n_nonzero_tally;

    logic                r_out_valid;
    mmcz_pkg::t_out_item r_out;

    // Request handshake; the block takes nothing while a compute is running.
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign compute_req = in_acc && (i_in.command == mmcz_pkg::CMD_COMPUTE);
    assign size_err    = !r_mode &&
                         (mmcz_pkg::clamp_dim(r_a_cols) != mmcz_pkg::clamp_dim(r_b_rows));
    assign start_ok    = compute_req && !size_err;

    // The whole pipeline moves only when the result register can take a result.
    assign en       = !r_out_valid || !i_out_stall;
    assign load_res = en && mac_res.valid;
    assign load_err = en && (r_state == ST_ERR);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_a_rows <= mmcz_pkg::DIM_W'(1);
            r_a_cols <= mmcz_pkg::DIM_W'(1);
            r_b_rows <= mmcz_pkg::DIM_W'(1);
            r_b_cols <= mmcz_pkg::DIM_W'(1);
            r_scalar <= mmcz_pkg::DATA_W'(65536);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mmcz_pkg::CFG_MODE:   r_mode   <= i_cfg_wdata[0];
                mmcz_pkg::CFG_A_ROWS: r_a_rows <= i_cfg_wdata[mmcz_pkg::DIM_W-1:0];
                mmcz_pkg::CFG_A_COLS: r_a_cols <= i_cfg_wdata[mmcz_pkg::DIM_W-1:0];
                mmcz_pkg::CFG_B_ROWS: r_b_rows <= i_cfg_wdata[mmcz_pkg::DIM_W-1:0];
                mmcz_pkg::CFG_B_COLS: r_b_cols <= i_cfg_wdata[mmcz_pkg::DIM_W-1:0];
                mmcz_pkg::CFG_SCALAR: r_scalar <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Loop bounds are captured when a compute starts.
    always_ff @(posedge i_clk) begin
        if (start_ok) begin
            r_last_i <= mmcz_pkg::last_idx(r_a_rows);
            r_last_j <= r_mode ? mmcz_pkg::last_idx(r_a_cols)
                               : mmcz_pkg::last_idx(r_b_cols);
            r_last_k <= r_mode ? '0 : mmcz_pkg::last_idx(r_a_cols);
        end
    end

    // Step of the current multiply-accumulate.
    assign issue_tag.valid     = (r_state == ST_RUN);
    assign issue_tag.first     = (r_k == '0);
    assign issue_tag.last_k    = (r_k == r_last_k);
    assign issue_tag.last_elem = (r_k == r_last_k) && (r_j == r_last_j) && (r_i == r_last_i);
    assign issue_tag.row       = r_i;
    assign issue_tag.col       = r_j;

    // Sequencer: inner index k, then column j, then row i.
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        case (r_state)
            ST_IDLE: begin
                if (compute_req) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                    n_state = size_err ? ST_ERR : ST_RUN;
                end
            end
            ST_RUN: begin
                if (en) begin
                    if (r_k != r_last_k) begin
                        n_k = r_k + mmcz_pkg::IDX_W'(1);
                    end else begin
                        n_k = '0;
                        if (r_j != r_last_j) begin
                            n_j = r_j + mmcz_pkg::IDX_W'(1);
                        end else begin
                            n_j = '0;
                            if (r_i != r_last_i) begin
                                n_i = r_i + mmcz_pkg::IDX_W'(1);
                            end else begin
                                n_state = ST_WAIT;
                            end
                        end
                    end
                end
            end
            ST_WAIT: begin
                if (load_res && mac_res.last_elem) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (load_err) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    // Element storage; a load request writes, the sequencer reads.
    mmcz_store u_store (
        .i_clk       (i_clk),
        .i_wr_a      (in_acc && (i_in.command == mmcz_pkg::CMD_LOAD_A)),
        .i_wr_b      (in_acc && (i_in.command == mmcz_pkg::CMD_LOAD_B)),
        .i_wr_addr   ({i_in.row, i_in.col}),
        .i_wr_data   (i_in.value),
        .i_rd_en     (en),
        .i_rd_addr_a ({r_i, (r_mode ? r_j : r_k)}),
        .i_rd_addr_b ({r_k, r_j}),
        .o_rd_a      (rd_a),
        .o_rd_b      (rd_b)
    );

    // Tag stage that lines up with the registered memory read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag <= '0;
        end else if (en) begin
            r_s1_tag <= issue_tag;
        end
    end

    // In scalar mode the second operand is the configured factor.
    assign op_b = r_mode ? r_scalar : rd_b;

    mmcz_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (r_s1_tag),
        .i_a     (rd_a),
        .i_b     (op_b),
        .o_res   (mac_res)
    );

    // Saturation and census of each finished element.
    assign sat_val         = mmcz_pkg::sat32(mac_res.acc);
    assign n_zero_tally    = r_zero_tally + mmcz_pkg::CNT_W'(sat_val == '0);
    assign n_nonzero_tally = r_nonzero_tally + mmcz_pkg::CNT_W'(sat_val != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_tally    <= '0;
            r_nonzero_tally <= '0;
        end else if (start_ok) begin
            r_zero_tally    <= '0;
            r_nonzero_tally <= '0;
        end else if (load_res) begin
            r_zero_tally    <= n_zero_tally;
            r_nonzero_tally <= n_nonzero_tally;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_res || load_err) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_res) begin
            r_out.out_row       <= mac_res.row;
            r_out.out_col       <= mac_res.col;
            r_out.out_value     <= sat_val;
            r_out.last          <= mac_res.last_elem;
            r_out.zero_count    <= mac_res.last_elem ? n_zero_tally : '0;
            r_out.nonzero_count <= mac_res.last_elem ? n_nonzero_tally : '0;
            r_out.size_error    <= 1'b0;
        end else if (load_err) begin
            r_out.out_row       <= '0;
            r_out.out_col       <= '0;
            r_out.out_value     <= '0;
            r_out.last          <= 1'b1;
            r_out.zero_count    <= '0;
            r_out.nonzero_count <= '0;
            r_out.size_error    <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Checks on the sequencer and the result stream.
    `ASSERT_IMPLY(a_idle_empty, i_clk, i_rst_n, r_state == ST_IDLE, !r_s1_tag.valid && !mac_res.valid)
    `ASSERT_NEXT(a_mismatch_err, i_clk, i_rst_n, compute_req && size_err, r_state == ST_ERR)
    `ASSERT_IMPLY(a_err_is_last, i_clk, i_rst_n, r_out_valid && r_out.size_error, r_out.last)
    `ASSERT_IMPLY(a_census_nonempty, i_clk, i_rst_n, r_out_valid && r_out.last && !r_out.size_error, (r_out.zero_count + r_out.nonzero_count) != '0)

endmodule

// ----- dv/tb_matrix_multiply_count_zeros.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for matrix_multiply_count_zeros: loads matrices, programs
// mode, sizes and scalar, and checks each product element against a predictor.
// Depends on mmcz_pkg and the matrix_multiply_count_zeros RTL.
module tb_matrix_multiply_count_zeros;

    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam bit         MODE_MATRIX   = 1'b0;
    localparam bit         MODE_SCALAR   = 1'b1;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         TAIL_CYCLES   = 20;
    localparam int         CYCLE_LIMIT   = 5_000_000;
    localparam int         TARGET_ITEMS  = 370;
    localparam longint     Q_MAX         = 64'sd2147483647;
    localparam longint     Q_MIN         = -64'sd2147483648;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    mmcz_pkg::t_in_item             in_req    = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    mmcz_pkg::t_out_item            out_res;
    logic                           cfg_we    = 1'b0;
    logic [mmcz_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mmcz_pkg::DATA_W-1:0]    cfg_wdata = '0;

    // Requests waiting to be sent and product elements waiting to arrive.
    mmcz_pkg::t_in_item  pending_reqs[$];
    mmcz_pkg::t_out_item product_elems_due[$];

    // Entries loaded since reset, tracked while building stimulus.
    bit [mmcz_pkg::DEPTH-1:0] a_loaded;
    bit [mmcz_pkg::DEPTH-1:0] b_loaded;
    int                       item_count;
    int                       mismatch_count;
    int                       cycle_count;
    bit                       quiet_phase;

    // Predictor copy of the matrices and the configuration.
    logic signed [mmcz_pkg::DATA_W-1:0] a_shadow[mmcz_pkg::DEPTH];
    logic signed [mmcz_pkg::DATA_W-1:0] b_shadow[mmcz_pkg::DEPTH];
    bit                                 shadow_mode;
    logic [mmcz_pkg::DIM_W-1:0]         shadow_a_rows;
    logic [mmcz_pkg::DIM_W-1:0]         shadow_a_cols;
    logic [mmcz_pkg::DIM_W-1:0]         shadow_b_rows;
    logic [mmcz_pkg::DIM_W-1:0]         shadow_b_cols;
    logic signed [mmcz_pkg::DATA_W-1:0] shadow_scalar;

    matrix_multiply_count_zeros dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_res),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // A size of zero acts as one, anything above the maximum as the maximum.
    function automatic int dim_used(input logic [mmcz_pkg::DIM_W-1:0] d);
        if (d == '0) return 1;
        if (d > mmcz_pkg::MAX_DIM) return mmcz_pkg::MAX_DIM;
        return int'(d);
    endfunction

    // Exact Q32.32 product rounded half up to Q16.16.
    function automatic longint round_product(input logic signed [mmcz_pkg::DATA_W-1:0] x,
                                             input logic signed [mmcz_pkg::DATA_W-1:0] y);
        longint p;
        p = longint'(x) * longint'(y) + 64'sd32768;
        return p >>> mmcz_pkg::FRAC_W;
    endfunction

    function automatic logic signed [mmcz_pkg::DATA_W-1:0] saturate_q16(input longint v);
        if (v > Q_MAX) return 32'h7fff_ffff;
        if (v < Q_MIN) return 32'h8000_0000;
        return mmcz_pkg::DATA_W'(v);
    endfunction

    // Apply one request to the predictor and queue the product elements it causes.
    task automatic predict_product(input mmcz_pkg::t_in_item req);
        int                                 rows;
        int                                 cols;
        int                                 inner;
        int                                 zeros;
        int                                 nonzeros;
        longint                             acc;
        logic signed [mmcz_pkg::DATA_W-1:0] elem;
        mmcz_pkg::t_out_item                res;
        rows     = dim_used(shadow_a_rows);
        inner    = dim_used(shadow_a_cols);
        cols     = (shadow_mode == MODE_MATRIX) ? dim_used(shadow_b_cols) : inner;
        zeros    = 0;
        nonzeros = 0;
        case (req.command)
            mmcz_pkg::CMD_LOAD_A: a_shadow[{req.row, req.col}] = req.value;
            mmcz_pkg::CMD_LOAD_B: b_shadow[{req.row, req.col}] = req.value;
            mmcz_pkg::CMD_COMPUTE: begin
                if (shadow_mode == MODE_MATRIX && inner != dim_used(shadow_b_rows)) begin
                    res            = '0;
                    res.last       = 1'b1;
                    res.size_error = 1'b1;
                    product_elems_due.insert(product_elems_due.size(), res);
                end else begin
                    for (int i = 0; i < rows; i++) begin
                        for (int j = 0; j < cols; j++) begin
                            if (shadow_mode == MODE_MATRIX) begin
                                acc = 0;
                                for (int k = 0; k < inner; k++)
                                    acc += round_product(
                                        a_shadow[i*mmcz_pkg::MAX_DIM+k],
                                        b_shadow[k*mmcz_pkg::MAX_DIM+j]);
                            end else begin
                                acc = round_product(a_shadow[i*mmcz_pkg::MAX_DIM+j],
                                                    shadow_scalar);
                            end
                            elem = saturate_q16(acc);
                            if (elem == 0) zeros++;
                            else nonzeros++;
                            res           = '0;
                            res.out_row   = mmcz_pkg::IDX_W'(i);
                            res.out_col   = mmcz_pkg::IDX_W'(j);
                            res.out_value = elem;
                            if (i == rows - 1 && j == cols - 1) begin
                                res.last          = 1'b1;
                                res.zero_count    = mmcz_pkg::CNT_W'(zeros);
                                res.nonzero_count = mmcz_pkg::CNT_W'(nonzeros);
                            end
                            product_elems_due.insert(product_elems_due.size(), res);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic bit same_result(input mmcz_pkg::t_out_item due,
                                       input mmcz_pkg::t_out_item got);
        return got.out_row === due.out_row && got.out_col === due.out_col
            && got.out_value === due.out_value && got.last === due.last
            && got.zero_count === due.zero_count
            && got.nonzero_count === due.nonzero_count
            && got.size_error === due.size_error;
    endfunction

    function automatic string show_result(input mmcz_pkg::t_out_item x);
        return $sformatf("(%0d,%0d) %h last %b zeros %0d nonzeros %0d err %b",
                         x.out_row, x.out_col, x.out_value, x.last, x.zero_count,
                         x.nonzero_count, x.size_error);
    endfunction

    task automatic report_mismatch(input string what, input mmcz_pkg::t_out_item due,
                                   input mmcz_pkg::t_out_item got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s at %0t: expected %s", what, $time, show_result(due));
            $display("    got %s", show_result(got));
        end
    endtask

    // Gap lengths: mostly none or short, now and then long; none in a quiet phase.
    function automatic int pick_gap();
        int pick;
        if (quiet_phase) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [mmcz_pkg::DIM_W-1:0] rand_dim();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) return mmcz_pkg::DIM_W'($urandom_range(1, 3));
        if (pick < 92) return mmcz_pkg::DIM_W'($urandom_range(4, mmcz_pkg::MAX_DIM));
        if (pick < 95) return '0;
        return mmcz_pkg::DIM_W'($urandom_range(mmcz_pkg::MAX_DIM + 1, 15));
    endfunction

    // Element values: zeros, corner values, small signed values and raw bit patterns.
    function automatic logic [mmcz_pkg::DATA_W-1:0] rand_elem();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) return '0;
        if (pick < 25) begin
            case ($urandom_range(0, 5))
                0: return 32'h7fff_ffff;
                1: return 32'h8000_0000;
                2: return 32'hffff_ffff;
                3: return 32'h0000_0001;
                4: return 32'h0001_0000;
                default: return 32'hffff_0000;
            endcase
        end
        if (pick < 65)
            return mmcz_pkg::DATA_W'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
        return $urandom;
    endfunction

    // Request sender: presents queued requests with random gaps between them.
    always @(posedge clk) begin : send_proc
        int gap_left;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid)
                gap_left = pick_gap();
            if (gap_left == 0 && pending_reqs.size() > 0) begin
                in_req   <= pending_reqs.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
        end
    end

    // Result receiver: stalls in runs of random length.
    always @(posedge clk) begin : stall_proc
        int stall_left;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    // Monitor: tracks register writes, predicts accepted requests, checks results.
    always @(posedge clk) begin : watch_proc
        mmcz_pkg::t_out_item due;
        if (!rst_n) begin
            shadow_mode   = MODE_MATRIX;
            shadow_a_rows = mmcz_pkg::DIM_W'(1);
            shadow_a_cols = mmcz_pkg::DIM_W'(1);
            shadow_b_rows = mmcz_pkg::DIM_W'(1);
            shadow_b_cols = mmcz_pkg::DIM_W'(1);
            shadow_scalar = 32'h0001_0000;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    mmcz_pkg::CFG_MODE:   shadow_mode   = cfg_wdata[0];
                    mmcz_pkg::CFG_A_ROWS: shadow_a_rows = cfg_wdata[mmcz_pkg::DIM_W-1:0];
                    mmcz_pkg::CFG_A_COLS: shadow_a_cols = cfg_wdata[mmcz_pkg::DIM_W-1:0];
                    mmcz_pkg::CFG_B_ROWS: shadow_b_rows = cfg_wdata[mmcz_pkg::DIM_W-1:0];
                    mmcz_pkg::CFG_B_COLS: shadow_b_cols = cfg_wdata[mmcz_pkg::DIM_W-1:0];
                    mmcz_pkg::CFG_SCALAR: shadow_scalar = cfg_wdata;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_product(in_req);
            if (out_valid && !out_stall) begin
                if (product_elems_due.size() == 0) begin
                    report_mismatch("unexpected result", '0, out_res);
                end else begin
                    due = product_elems_due.pop_front();
                    if (!same_result(due, out_res))
                        report_mismatch("wrong result", due, out_res);
                end
            end
        end
    end

    // Run limit, far above the slowest correct run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic queue_req(input logic [1:0] cmd, input int row, input int col,
                             input logic [mmcz_pkg::DATA_W-1:0] value);
        mmcz_pkg::t_in_item req;
        req.command = cmd;
        req.row     = mmcz_pkg::IDX_W'(row);
        req.col     = mmcz_pkg::IDX_W'(col);
        req.value   = value;
        pending_reqs.insert(pending_reqs.size(), req);
        if (cmd == mmcz_pkg::CMD_LOAD_A) a_loaded[{req.row, req.col}] = 1'b1;
        if (cmd == mmcz_pkg::CMD_LOAD_B) b_loaded[{req.row, req.col}] = 1'b1;
        if (cmd != CMD_UNUSED) item_count++;
    endtask

    // Load every entry of the region that a compute will read and that is still unset.
    task automatic fill_unwritten(input logic [1:0] cmd, input int rows, input int cols);
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                if (cmd == mmcz_pkg::CMD_LOAD_A ? !a_loaded[r*mmcz_pkg::MAX_DIM+c]
                                                : !b_loaded[r*mmcz_pkg::MAX_DIM+c])
                    queue_req(cmd, r, c, rand_elem());
            end
        end
    endtask

    // Wait until every request is sent and every expected element has arrived.
    task automatic drain();
        while (pending_reqs.size() != 0 || in_valid || product_elems_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [mmcz_pkg::CFG_IDX_W-1:0] index,
                             input logic [mmcz_pkg::DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
    endtask

    // Registers change only once the block has gone idle.
    task automatic program_regs(input bit mode, input logic [mmcz_pkg::DIM_W-1:0] ar,
                                input logic [mmcz_pkg::DIM_W-1:0] ac,
                                input logic [mmcz_pkg::DIM_W-1:0] br,
                                input logic [mmcz_pkg::DIM_W-1:0] bc,
                                input logic [mmcz_pkg::DATA_W-1:0] scalar);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(mmcz_pkg::CFG_MODE, mmcz_pkg::DATA_W'(mode));
        write_reg(mmcz_pkg::CFG_A_ROWS, mmcz_pkg::DATA_W'(ar));
        write_reg(mmcz_pkg::CFG_A_COLS, mmcz_pkg::DATA_W'(ac));
        write_reg(mmcz_pkg::CFG_B_ROWS, mmcz_pkg::DATA_W'(br));
        write_reg(mmcz_pkg::CFG_B_COLS, mmcz_pkg::DATA_W'(bc));
        write_reg(mmcz_pkg::CFG_SCALAR, scalar);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One setting, then rounds of loads followed by a compute.
    // A big_mode of 0 or 1 forces the largest sizes in that mode.
    task automatic random_phase(input int big_mode);
        bit                         mode;
        logic [mmcz_pkg::DIM_W-1:0] ar;
        logic [mmcz_pkg::DIM_W-1:0] ac;
        logic [mmcz_pkg::DIM_W-1:0] br;
        logic [mmcz_pkg::DIM_W-1:0] bc;
        logic [1:0]                 cmd;
        int                         rows;
        int                         inner;
        int                         cols;
        int                         r;
        int                         c;
        if (big_mode >= 0) begin
            mode = big_mode[0];
            ar   = mmcz_pkg::DIM_W'(mmcz_pkg::MAX_DIM);
            ac   = 4'd15;
            br   = mmcz_pkg::DIM_W'(mmcz_pkg::MAX_DIM);
            bc   = 4'd9;
        end else begin
            mode = $urandom_range(0, 1);
            ar   = rand_dim();
            ac   = rand_dim();
            br   = rand_dim();
            bc   = rand_dim();
            if ($urandom_range(0, 99) < 85)
                br = ac;
        end
        program_regs(mode, ar, ac, br, bc, rand_elem());
        quiet_phase = ($urandom_range(0, 4) == 0);
        rows  = dim_used(ar);
        inner = dim_used(ac);
        cols  = (mode == MODE_MATRIX) ? dim_used(bc) : inner;
        repeat ($urandom_range(1, 3)) begin
            // Overwrites mostly inside the region in use, plus some ignored commands.
            repeat ($urandom_range(0, 6)) begin
                if ($urandom_range(0, 9) == 0)
                    cmd = CMD_UNUSED;
                else
                    cmd = $urandom_range(0, 1) ? mmcz_pkg::CMD_LOAD_B : mmcz_pkg::CMD_LOAD_A;
                if (cmd != CMD_UNUSED && $urandom_range(0, 9) < 7) begin
                    r = $urandom_range(0, (cmd == mmcz_pkg::CMD_LOAD_B ? inner : rows) - 1);
                    c = $urandom_range(0, (cmd == mmcz_pkg::CMD_LOAD_B ? cols : inner) - 1);
                end else begin
                    r = $urandom_range(0, mmcz_pkg::MAX_DIM - 1);
                    c = $urandom_range(0, mmcz_pkg::MAX_DIM - 1);
                end
                queue_req(cmd, r, c, rand_elem());
            end
            if (mode == MODE_SCALAR || inner == dim_used(br)) begin
                fill_unwritten(mmcz_pkg::CMD_LOAD_A, rows, inner);
                if (mode == MODE_MATRIX)
                    fill_unwritten(mmcz_pkg::CMD_LOAD_B, inner, cols);
            end
            queue_req(mmcz_pkg::CMD_COMPUTE, $urandom, $urandom, $urandom);
            if ($urandom_range(0, 3) == 0)
                drain();
        end
    endtask

    // Stimulus: reset, directed corner cases, then random phases.
    initial begin : stimulus
        int phase_no;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Saturation at both ends and a zero element with the reset sizes of one.
        queue_req(mmcz_pkg::CMD_LOAD_A, 0, 0, 32'h7fff_ffff);
        queue_req(mmcz_pkg::CMD_LOAD_B, 0, 0, 32'h7fff_ffff);
        queue_req(mmcz_pkg::CMD_COMPUTE, 0, 0, 32'h0000_0000);
        queue_req(mmcz_pkg::CMD_LOAD_B, 0, 0, 32'h8000_0000);
        queue_req(mmcz_pkg::CMD_COMPUTE, 7, 7, 32'hffff_ffff);
        queue_req(mmcz_pkg::CMD_LOAD_A, 0, 0, 32'h0000_0000);
        queue_req(mmcz_pkg::CMD_COMPUTE, 0, 0, 32'h0000_0000);
        queue_req(CMD_UNUSED, $urandom, $urandom, $urandom);
        queue_req(mmcz_pkg::CMD_LOAD_A, 7, 7, 32'h8000_0000);
        queue_req(mmcz_pkg::CMD_LOAD_B, 7, 7, 32'hffff_ffff);

        // Exact halves: a positive half rounds up, a negative half rounds to zero.
        queue_req(mmcz_pkg::CMD_LOAD_A, 0, 0, 32'h0000_0001);
        queue_req(mmcz_pkg::CMD_LOAD_B, 0, 0, 32'h0000_8000);
        queue_req(mmcz_pkg::CMD_COMPUTE, 0, 0, 32'h0000_0000);
        queue_req(mmcz_pkg::CMD_LOAD_A, 0, 0, 32'hffff_ffff);
        queue_req(mmcz_pkg::CMD_COMPUTE, 0, 0, 32'h0000_0000);

        // Inner sizes differ: a single error result.
        program_regs(MODE_MATRIX, 4'd0, 4'd2, 4'd1, 4'd15, 32'h0001_0000);
        queue_req(mmcz_pkg::CMD_COMPUTE, 0, 0, 32'h0000_0000);

        // Scalar mode ignores the B sizes; the most negative value squared saturates.
        program_regs(MODE_SCALAR, 4'd1, 4'd1, 4'd5, 4'd0, 32'h8000_0000);
        queue_req(mmcz_pkg::CMD_LOAD_A, 0, 0, 32'h8000_0000);
        queue_req(mmcz_pkg::CMD_COMPUTE, 0, 0, 32'h0000_0000);
        queue_req(mmcz_pkg::CMD_LOAD_A, 0, 0, 32'h0001_0000);
        queue_req(mmcz_pkg::CMD_COMPUTE, 0, 0, 32'h0000_0000);

        // Random phases, with two at the largest sizes.
        phase_no = 0;
        while (item_count < TARGET_ITEMS) begin
            case (phase_no)
                3: random_phase(int'(MODE_MATRIX));
                7: random_phase(int'(MODE_SCALAR));
                default: random_phase(-1);
            endcase
            phase_no++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && product_elems_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/mmcz_pkg.sv
hdl/mmcz_store.sv
hdl/mmcz_mac.sv
hdl/matrix_multiply_count_zeros.sv
dv/tb_matrix_multiply_count_zeros.sv
